// File: hw/rtl/spq_pkg.sv
// Package for the sorted-array priority queue: the entry layout, command and
// status codes, and the one-hot controller state type. No dependencies.
`default_nettype none

package spq_pkg;

    // One stored entry: priority number in the upper bits, value below it.
    typedef struct packed {
        logic signed [15:0] pri;
        logic signed [31:0] val;
    } t_entry;

    // Operation codes carried on the cmd field.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Status codes returned with every result.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // Controller states, one-hot.
    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_INS_CMP   = 6'b000010,
        S_INS_PUT   = 6'b000100,
        S_REM_HEAD  = 6'b001000,
        S_REM_SHIFT = 6'b010000,
        S_RESULT    = 6'b100000
    } t_state;

endpackage

`default_nettype wire

// File: hw/rtl/sorted_array_priority_queue_core.sv
// Top level of the sorted-array priority queue: a single-port-write entry
// memory with a registered read, walked by a small controller.
// Depends on spq_pkg.
`default_nettype none

// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_ready   i_cmd, i_item_value, i_item_priority
// output    out        o_out_valid / i_out_ready o_removed_value, o_removed_priority,
//                                                o_status, o_occupancy
//
// An insert into a non-empty queue steps back from the tail over each stored entry
// with a priority number not smaller than the new one, moving it up one place,
// then writes the new entry; an insert into an empty queue writes it straight to
// the head. A remove reads the head, then moves every remaining entry down one
// place through the single read port and the single write port of the entry
// memory. Overflow and underflow go straight to the result stage, which holds
// while a waiting result holds the output register.
// Reset (synchronous, active low) clears the controller, the entry count and
// the output valid flag only; the memory is never cleared.
// The finished result sits in an output register, so the next transfer is
// taken while the previous result is still waiting on i_out_ready.

module sorted_array_priority_queue_core #(
    parameter int CAPACITY = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic                i_cmd,
    input  wire logic signed [31:0]  i_item_value,
    input  wire logic signed [15:0]  i_item_priority,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic signed [31:0]       o_removed_value,
    output logic signed [15:0]       o_removed_priority,
    output logic [1:0]               o_status,
    output logic [3:0]               o_occupancy
);
    import spq_pkg::*;

    // Count width holds CAPACITY itself; index width addresses the memory.
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    // Entry memory: one write and one registered read per cycle.
    t_entry          mem [CAPACITY];
    t_entry          r_rd_data;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    t_entry          wr_data;
    logic [IW-1:0]   rd_addr;

    // Controller and work registers.
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_pos, n_pos;
    t_entry          r_item, n_item;
    t_entry          r_res, n_res;
    t_status         r_res_status, n_res_status;

    // Output register.
    logic            r_out_valid, n_out_valid;
    t_entry          r_out, n_out;
    t_status         r_out_status, n_out_status;
    logic [3:0]      r_out_occ, n_out_occ;

    logic            accept;
    logic            out_free;
    logic [CW-1:0]   pos_m1;
    logic [CW-1:0]   pos_m2;
    logic [CW-1:0]   pos_p1;
    t_entry          in_entry;

    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign pos_m1   = r_pos - CW'(1);
    assign pos_m2   = r_pos - CW'(2);
    assign pos_p1   = r_pos + CW'(1);

    assign in_entry.pri = i_item_priority;
    assign in_entry.val = i_item_value;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_item       = r_item;
        n_res        = r_res;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_out_status = r_out_status;
        n_out_occ    = r_out_occ;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = r_item;
        rd_addr      = '0;

        // A waiting result leaves once it has been taken.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_item       = in_entry;
                    n_res        = '0;
                    n_res_status = ST_OK;
                    if (i_cmd == CMD_INSERT) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_res_status = ST_OVERFLOW;
                            n_state      = S_RESULT;
                        end else if (r_count == '0) begin
                            // Empty queue: the new entry becomes the head.
                            wr_en   = 1'b1;
                            wr_addr = '0;
                            wr_data = in_entry;
                            n_count = CW'(1);
                            n_state = S_RESULT;
                        end else begin
                            // Start the walk back from the tail.
                            n_pos   = r_count;
                            rd_addr = IW'(r_count - CW'(1));
                            n_state = S_INS_CMP;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res_status = ST_UNDERFLOW;
                            n_state      = S_RESULT;
                        end else begin
                            rd_addr = '0;
                            n_state = S_REM_HEAD;
                        end
                    end
                end
            end

            S_INS_CMP: begin
                // r_rd_data holds the entry just below r_pos.
                if (r_rd_data.pri >= r_item.pri) begin
                    // Not smaller: the stored entry moves up one place.
                    wr_en   = 1'b1;
                    wr_addr = r_pos[IW-1:0];
                    wr_data = r_rd_data;
                    n_pos   = pos_m1;
                    if (r_pos == CW'(1)) begin
                        n_state = S_INS_PUT;
                    end else begin
                        rd_addr = pos_m2[IW-1:0];
                    end
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_pos[IW-1:0];
                    wr_data = r_item;
                    n_count = r_count + CW'(1);
                    n_state = S_RESULT;
                end
            end

            S_INS_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_pos[IW-1:0];
                wr_data = r_item;
                n_count = r_count + CW'(1);
                n_state = S_RESULT;
            end

            S_REM_HEAD: begin
                n_res = r_rd_data;
                if (r_count == CW'(1)) begin
                    n_count = '0;
                    n_state = S_RESULT;
                end else begin
                    n_pos   = CW'(1);
                    rd_addr = IW'(1);
                    n_state = S_REM_SHIFT;
                end
            end

            S_REM_SHIFT: begin
                // Entry r_pos moves down to r_pos - 1.
                wr_en   = 1'b1;
                wr_addr = pos_m1[IW-1:0];
                wr_data = r_rd_data;
                if (pos_p1 < r_count) begin
                    n_pos   = pos_p1;
                    rd_addr = pos_p1[IW-1:0];
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_RESULT;
                end
            end

            S_RESULT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out        = r_res;
                    n_out_status = r_res_status;
                    n_out_occ    = 4'(r_count);
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_item       <= n_item;
        r_res        <= n_res;
        r_res_status <= n_res_status;
        r_out        <= n_out;
        r_out_status <= n_out_status;
        r_out_occ    <= n_out_occ;
    end

    // Inserts and failed operations carry a zero entry in the result register.
    assign o_in_ready         = (r_state == S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_removed_value    = r_out.val;
    assign o_removed_priority = r_out.pri;
    assign o_status           = r_out_status;
    assign o_occupancy        = r_out_occ;

endmodule

`default_nettype wire

// File: tb/sorted_array_priority_queue_core_test.sv
// Self-checking testbench for sorted_array_priority_queue_core: a directed table, then
// random insert and remove transfers checked against a behavioural queue model.
// Depends on spq_pkg and the core RTL.
`default_nettype none

module sorted_array_priority_queue_core_test;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH  = 8;
    localparam int RANDOM_ITEMS = 1030;
    localparam int QUIET_ITEMS  = 100;
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [15:0] prio;
        t_status            status;
        logic [3:0]         occupancy;
    } queue_result_t;

    typedef struct {
        logic               cmd;
        logic signed [31:0] value;
        logic signed [15:0] prio;
        bit                 has_known;
        queue_result_t      known;
    } stim_row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_cmd;
    logic signed [31:0] i_item_value;
    logic signed [15:0] i_item_priority;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_removed_value;
    logic signed [15:0] o_removed_priority;
    logic [1:0]         o_status;
    logic [3:0]         o_occupancy;

    // Behavioural copy of the queue contents.
    t_entry             held_entries [QUEUE_DEPTH];
    int                 held_count;

    queue_result_t      pending_results [$];
    stim_row_t          directed_rows [23];

    int                 error_count;
    int                 items_sent;
    int                 results_checked;
    int                 overflow_count;
    int                 underflow_count;
    int                 in_gap_odds;
    int                 out_stall_odds;
    int                 idle_cycles;

    sorted_array_priority_queue_core #(
        .CAPACITY(QUEUE_DEPTH)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_cmd             (i_cmd),
        .i_item_value      (i_item_value),
        .i_item_priority   (i_item_priority),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_removed_value   (o_removed_value),
        .o_removed_priority(o_removed_priority),
        .o_status          (o_status),
        .o_occupancy       (o_occupancy)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Applies one operation to the model queue and returns the result it should give.
    function automatic queue_result_t apply_queue_op(logic cmd, logic signed [31:0] value,
                                                     logic signed [15:0] prio);
        queue_result_t res;
        int            slot;
        int            k;
        res = '{32'sd0, 16'sd0, ST_OK, 4'd0};
        if (cmd == CMD_INSERT) begin
            if (held_count >= QUEUE_DEPTH) begin
                res.status = ST_OVERFLOW;
            end else begin
                // Step back over every entry whose number is not smaller, so that
                // the newest of equal numbers ends up nearest the head.
                slot = held_count;
                while (slot > 0 && held_entries[slot - 1].pri >= prio)
                    slot--;
                for (k = held_count; k > slot; k--)
                    held_entries[k] = held_entries[k - 1];
                held_entries[slot].val = value;
                held_entries[slot].pri = prio;
                held_count++;
            end
        end else begin
            if (held_count == 0) begin
                res.status = ST_UNDERFLOW;
            end else begin
                res.value = held_entries[0].val;
                res.prio  = held_entries[0].pri;
                for (k = 1; k < held_count; k++)
                    held_entries[k - 1] = held_entries[k];
                held_count--;
            end
        end
        res.occupancy = held_count[3:0];
        return res;
    endfunction

    // Often a narrow band around zero so that ties are common, some extremes,
    // and the rest spread over the whole range.
    function automatic logic signed [15:0] pick_priority();
        logic signed [15:0] p;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                p = 16'($urandom_range(0, 4));
                p = p - 16'sd2;
            end
            4: begin
                case ($urandom_range(0, 3))
                    0: p = 16'sh8000;
                    1: p = 16'sh7FFF;
                    2: p = 16'sd0;
                    default: p = -16'sd1;
                endcase
            end
            default: p = 16'($urandom());
        endcase
        return p;
    endfunction

    // Presents one transfer, holds it until it is taken, then records what it should produce.
    task automatic send_item(logic cmd, logic signed [31:0] value, logic signed [15:0] prio,
                             bit has_known, queue_result_t known);
        queue_result_t predicted;
        int            gap;
        if (in_gap_odds != 0 && $urandom_range(1, in_gap_odds) == 1) begin
            gap = $urandom_range(1, 16);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_cmd           <= cmd;
        i_item_value    <= value;
        i_item_priority <= prio;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = apply_queue_op(cmd, value, prio);
        if (predicted.status == ST_OVERFLOW)
            overflow_count++;
        if (predicted.status == ST_UNDERFLOW)
            underflow_count++;
        pending_results.push_back(has_known ? known : predicted);
        items_sent++;
    endtask

    // Drops valid and holds off until every outstanding result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic check_result();
        queue_result_t want;
        if (pending_results.size() == 0) begin
            $error("result transfer with nothing outstanding: value %0d priority %0d status %0d",
                   o_removed_value, o_removed_priority, o_status);
            error_count++;
        end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (o_removed_value !== want.value) begin
                $error("removed_value: expected %0d, got %0d", want.value, o_removed_value);
                error_count++;
            end
            if (o_removed_priority !== want.prio) begin
                $error("removed_priority: expected %0d, got %0d", want.prio,
                       o_removed_priority);
                error_count++;
            end
            if (o_status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, o_status);
                error_count++;
            end
            if (o_occupancy !== want.occupancy) begin
                $error("occupancy: expected %0d, got %0d", want.occupancy, o_occupancy);
                error_count++;
            end
        end
    endtask

    // Result side: checks every result transfer and stalls in random bursts.
    initial begin : result_side
        int stall_left;
        stall_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                check_result();
            if (stall_left > 0)
                stall_left--;
            else if (out_stall_odds != 0 && $urandom_range(1, out_stall_odds) == 1)
                stall_left = $urandom_range(1, 16);
            i_out_ready <= (stall_left == 0);
        end
    end

    // Watchdog on cycles with no transfer on either side.
    initial begin : watchdog
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d cycles without a transfer", IDLE_LIMIT);
                $display("sorted_array_priority_queue_core_test failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int               n;
        int               insert_bias;
        logic             cmd;
        logic signed [31:0] value;
        logic signed [15:0] prio;
        queue_result_t    no_known;

        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_cmd           = CMD_INSERT;
        i_item_value    = 32'sd0;
        i_item_priority = 16'sd0;
        held_count      = 0;
        error_count     = 0;
        items_sent      = 0;
        results_checked = 0;
        overflow_count  = 0;
        underflow_count = 0;
        in_gap_odds     = 3;
        out_stall_odds  = 3;
        insert_bias     = 50;
        no_known        = '{32'sd0, 16'sd0, ST_OK, 4'd0};

        // Known rows: removal from empty, both priority extremes, ties at zero and at
        // the top, filling to capacity, overflow, draining and underflow again.
        directed_rows = '{
            '{CMD_REMOVE, 32'sd0,          16'sd0,     1'b1, '{0, 0, ST_UNDERFLOW, 4'd0}},
            '{CMD_INSERT, 32'sh7FFF_FFFF,  16'sh7FFF,  1'b1, '{0, 0, ST_OK, 4'd1}},
            '{CMD_INSERT, 32'sh8000_0000,  16'sh8000,  1'b1, '{0, 0, ST_OK, 4'd2}},
            '{CMD_INSERT, 32'sd0,          16'sd0,     1'b1, '{0, 0, ST_OK, 4'd3}},
            '{CMD_INSERT, -32'sd1,         16'sd0,     1'b1, '{0, 0, ST_OK, 4'd4}},
            '{CMD_INSERT, 32'sd5,          16'sd0,     1'b1, '{0, 0, ST_OK, 4'd5}},
            '{CMD_INSERT, 32'sh5555_5555,  16'sh5555,  1'b1, '{0, 0, ST_OK, 4'd6}},
            '{CMD_INSERT, 32'shAAAA_AAAA,  16'shAAAA,  1'b1, '{0, 0, ST_OK, 4'd7}},
            '{CMD_INSERT, 32'sd9,          16'sh7FFF,  1'b1, '{0, 0, ST_OK, 4'd8}},
            '{CMD_INSERT, 32'sd123,        16'sd1,     1'b1, '{0, 0, ST_OVERFLOW, 4'd8}},
            '{CMD_INSERT, 32'sh8000_0000,  16'sh8000,  1'b1, '{0, 0, ST_OVERFLOW, 4'd8}},
            '{CMD_REMOVE, 32'shDEAD_BEEF,  16'sh1234,  1'b0, no_known},
            '{CMD_REMOVE, 32'sd0,          16'sd0,     1'b0, no_known},
            '{CMD_REMOVE, -32'sd1,         -16'sd1,    1'b0, no_known},
            '{CMD_REMOVE, 32'sd0,          16'sd0,     1'b0, no_known},
            '{CMD_REMOVE, 32'sd0,          16'sd0,     1'b0, no_known},
            '{CMD_REMOVE, 32'sd0,          16'sd0,     1'b0, no_known},
            '{CMD_REMOVE, 32'sd0,          16'sd0,     1'b0, no_known},
            '{CMD_REMOVE, 32'sd0,          16'sd0,     1'b0, no_known},
            '{CMD_REMOVE, 32'sd0,          16'sd0,     1'b1, '{0, 0, ST_UNDERFLOW, 4'd0}},
            '{CMD_INSERT, 32'sd17,         -16'sd1,    1'b1, '{0, 0, ST_OK, 4'd1}},
            '{CMD_REMOVE, 32'sd0,          16'sd0,     1'b0, no_known},
            '{CMD_REMOVE, 32'sd0,          16'sd0,     1'b1, '{0, 0, ST_UNDERFLOW, 4'd0}}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r])
            send_item(directed_rows[r].cmd, directed_rows[r].value, directed_rows[r].prio,
                      directed_rows[r].has_known, directed_rows[r].known);
        drain_results();

        // Random phases of 40 transfers lean towards filling, draining or neither,
        // each with its own amount of idling on both sides.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: insert_bias = 80;
                    1: insert_bias = 25;
                    default: insert_bias = 55;
                endcase
                case ($urandom_range(0, 2))
                    0: begin
                        in_gap_odds    = 0;
                        out_stall_odds = 0;
                    end
                    1: begin
                        in_gap_odds    = 4;
                        out_stall_odds = 4;
                    end
                    default: begin
                        in_gap_odds    = 12;
                        out_stall_odds = 6;
                    end
                endcase
            end
            if (n >= RANDOM_ITEMS - QUIET_ITEMS) begin
                in_gap_odds    = 0;
                out_stall_odds = 0;
            end
            if (n == RANDOM_ITEMS / 2)
                drain_results();
            cmd   = ($urandom_range(0, 99) < insert_bias) ? CMD_INSERT : CMD_REMOVE;
            value = $urandom();
            prio  = pick_priority();
            send_item(cmd, value, prio, 1'b0, no_known);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d operations sent, %0d results checked, %0d of them overflows and %0d underflows",
                 items_sent, results_checked, overflow_count, underflow_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("sorted_array_priority_queue_core_test passed");
        end else begin
            if (pending_results.size() != 0) begin
                $error("%0d results never arrived", pending_results.size());
            end
            $display("sorted_array_priority_queue_core_test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
